// ===== hdl/ssll_pkg.sv =====
// Package for the sorted static linked list: capacity, derived widths,
// value and status types. No dependencies.
package ssll_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int LINK_W   = $clog2(CAPACITY + 1);
	localparam int VALUE_W  = 32;
	localparam int SLOT_W   = 4;

	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [LINK_W-1:0]         link_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [SLOT_W-1:0]         slot_t;

	// link value that ends the chain
	localparam link_t NULL_LINK = link_t'(CAPACITY);

	// request modes
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_ELEMENT  = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

endpackage

// ===== hdl/ssll_if.sv =====
// Request and result channel interfaces of the sorted static linked list.
// Depends on ssll_pkg.
interface ssll_req_if import ssll_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   mode;
	value_t new_value;

	modport source(output valid, output mode, output new_value, input ready);
	modport sink(input valid, input mode, input new_value, output ready);
endinterface

interface ssll_rsp_if import ssll_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	value_t  item_value;
	slot_t   slot_index;
	logic    last;

	modport source(output valid, output status, output item_value, output slot_index,
		output last, input ready);
	modport sink(input valid, input status, input item_value, input slot_index,
		input last, output ready);
endinterface

// ===== hdl/sorted_static_linked_list.sv =====
// Sorted static linked list: request channel in, result channel out.
// Depends on ssll_pkg and the interfaces in ssll_if.sv.
//
// Usage:
//   req carries mode and new_value. Mode 0 inserts new_value into the next
//   free slot and links it in ascending order after any equal values; one
//   result comes back (inserted with its slot, or full). Mode 1 walks the
//   chain and sends one result per stored value in ascending order, last
//   set on the final one; an empty list gives a single empty result.
//   One request is worked at a time; req.ready is high only between them.
// Microcode loop: one step reads the slot memory (registered read port),
//   the next compares (insert) or emits (read) and follows the link.
// Results go through an output register; a stalled receiver holds the
//   sequencer on its emit step, so nothing is lost or repeated.
// Reset (arst_n low) empties the list and drops any pending result. Slot
//   memory contents are not cleared; only written slots are ever read.
module sorted_static_linked_list import ssll_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ssll_req_if.sink    req,
	ssll_rsp_if.source  rsp
);

	typedef logic [3:0] upc_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_READ,
		OP_ADVANCE,
		OP_WR_NEW,
		OP_WR_PREV,
		OP_EMIT_FULL,
		OP_EMIT_ELEM,
		OP_EMIT_EMPTY
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NO_REQ,
		C_MODE_READ,
		C_FULL,
		C_WALK_DONE,
		C_NOT_STOP,
		C_NOT_LAST
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		logic  use_out;
		upc_t  target;
	} ctrl_t;

	// program addresses
	localparam upc_t U_IDLE     = 4'd0;
	localparam upc_t U_DISPATCH = 4'd1;
	localparam upc_t U_FULL_CHK = 4'd2;
	localparam upc_t U_INS_READ = 4'd3;
	localparam upc_t U_INS_ADV  = 4'd4;
	localparam upc_t U_WR_NEW   = 4'd5;
	localparam upc_t U_WR_PREV  = 4'd6;
	localparam upc_t U_FULL     = 4'd7;
	localparam upc_t U_RD_CHK   = 4'd8;
	localparam upc_t U_RD_READ  = 4'd9;
	localparam upc_t U_RD_EMIT  = 4'd10;
	localparam upc_t U_RD_END   = 4'd11;
	localparam upc_t U_EMPTY    = 4'd12;

	// control store: jump to target when cond holds, else fall through
	function automatic ctrl_t ucode(input upc_t a);
		ctrl_t w;
		w = '{op: OP_NONE, cond: C_ALWAYS, use_out: 1'b0, target: U_IDLE};
		case (a)
			U_IDLE:     w = '{op: OP_LATCH,      cond: C_NO_REQ,    use_out: 1'b0,
				target: U_IDLE};
			U_DISPATCH: w = '{op: OP_NONE,       cond: C_MODE_READ, use_out: 1'b0,
				target: U_RD_CHK};
			U_FULL_CHK: w = '{op: OP_NONE,       cond: C_FULL,      use_out: 1'b0,
				target: U_FULL};
			U_INS_READ: w = '{op: OP_READ,       cond: C_WALK_DONE, use_out: 1'b0,
				target: U_WR_NEW};
			U_INS_ADV:  w = '{op: OP_ADVANCE,    cond: C_NOT_STOP,  use_out: 1'b0,
				target: U_INS_READ};
			U_WR_NEW:   w = '{op: OP_WR_NEW,     cond: C_ALWAYS,    use_out: 1'b0,
				target: U_WR_PREV};
			U_WR_PREV:  w = '{op: OP_WR_PREV,    cond: C_ALWAYS,    use_out: 1'b1,
				target: U_IDLE};
			U_FULL:     w = '{op: OP_EMIT_FULL,  cond: C_ALWAYS,    use_out: 1'b1,
				target: U_IDLE};
			U_RD_CHK:   w = '{op: OP_NONE,       cond: C_WALK_DONE, use_out: 1'b0,
				target: U_EMPTY};
			U_RD_READ:  w = '{op: OP_READ,       cond: C_ALWAYS,    use_out: 1'b0,
				target: U_RD_EMIT};
			U_RD_EMIT:  w = '{op: OP_EMIT_ELEM,  cond: C_NOT_LAST,  use_out: 1'b1,
				target: U_RD_READ};
			U_RD_END:   w = '{op: OP_NONE,       cond: C_ALWAYS,    use_out: 1'b0,
				target: U_IDLE};
			U_EMPTY:    w = '{op: OP_EMIT_EMPTY, cond: C_ALWAYS,    use_out: 1'b1,
				target: U_IDLE};
			default:    w = '{op: OP_NONE,       cond: C_ALWAYS,    use_out: 1'b0,
				target: U_IDLE};
		endcase
		return w;
	endfunction

	// slot memories
	value_t slot_values [CAPACITY];
	link_t  slot_links  [CAPACITY];

	// sequencer and list state
	upc_t   upc_q;
	link_t  head_q;
	link_t  count_q;

	// working registers of the current request
	logic   mode_q;
	value_t x_q;
	link_t  cur_q;
	idx_t   prev_q;
	logic   has_prev_q;
	link_t  steps_q;
	value_t rd_val_q;
	link_t  rd_link_q;

	// output register
	logic    out_valid_q;
	status_t status_q;
	value_t  item_value_q;
	slot_t   slot_index_q;
	logic    last_q;

	ctrl_t  cw;
	logic   accept;
	logic   stall;
	logic   full;
	logic   walk_done;
	logic   stop;
	logic   last_elem;
	logic   cond_true;
	logic   do_op;
	logic   emit;
	idx_t   count_idx;
	link_t  new_link;
	logic   link_we;
	idx_t   link_waddr;
	link_t  link_wdata;
	upc_t   upc_next;

	assign cw        = ucode(upc_q);
	assign req.ready = (upc_q == U_IDLE);
	assign accept    = req.valid && req.ready;

	// hold an emit step while the result register is still taken
	assign stall = cw.use_out && out_valid_q && !rsp.ready;
	assign do_op = !stall;

	// datapath flags
	assign full      = (count_q >= NULL_LINK);
	assign walk_done = (cur_q >= NULL_LINK) || (steps_q >= count_q);
	assign stop      = (rd_val_q > x_q);
	assign last_elem = (rd_link_q >= NULL_LINK) || (link_t'(steps_q + 1'b1) >= count_q);
	assign count_idx = count_q[IDX_W-1:0];
	assign new_link  = (cur_q >= NULL_LINK) ? NULL_LINK : cur_q;

	always_comb begin
		case (cw.cond)
			C_ALWAYS:    cond_true = 1'b1;
			C_NO_REQ:    cond_true = !accept;
			C_MODE_READ: cond_true = (mode_q == MODE_READ);
			C_FULL:      cond_true = full;
			C_WALK_DONE: cond_true = walk_done;
			C_NOT_STOP:  cond_true = !stop;
			C_NOT_LAST:  cond_true = !last_elem;
			default:     cond_true = 1'b1;
		endcase
	end

	always_comb begin
		if (stall) begin
			upc_next = upc_q;
		end else if (cond_true) begin
			upc_next = cw.target;
		end else begin
			upc_next = upc_t'(upc_q + 1'b1);
		end
	end

	assign emit = do_op &&
		(cw.op inside {OP_WR_PREV, OP_EMIT_FULL, OP_EMIT_ELEM, OP_EMIT_EMPTY});

	// single link write port: new slot's link, then predecessor's link
	assign link_we    = do_op && ((cw.op == OP_WR_NEW) || (cw.op == OP_WR_PREV && has_prev_q));
	assign link_waddr = (cw.op == OP_WR_NEW) ? count_idx : prev_q;
	assign link_wdata = (cw.op == OP_WR_NEW) ? new_link : count_q;

	// slot memories: one write port each, registered read at cur
	always_ff @(posedge clk) begin
		if (do_op && cw.op == OP_WR_NEW) begin
			slot_values[count_idx] <= x_q;
		end
		if (link_we) begin
			slot_links[link_waddr] <= link_wdata;
		end
		if (do_op && cw.op == OP_READ) begin
			rd_val_q  <= slot_values[cur_q[IDX_W-1:0]];
			rd_link_q <= slot_links[cur_q[IDX_W-1:0]];
		end
	end

	// control state: program counter, list head, fill count, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= U_IDLE;
			head_q      <= NULL_LINK;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_next;
			if (do_op && cw.op == OP_WR_PREV) begin
				if (!has_prev_q) begin
					head_q <= count_q;
				end
				count_q <= link_t'(count_q + 1'b1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		if (do_op) begin
			case (cw.op)
				OP_LATCH: begin
					if (accept) begin
						mode_q     <= req.mode;
						x_q        <= req.new_value;
						cur_q      <= head_q;
						steps_q    <= '0;
						has_prev_q <= 1'b0;
					end
				end
				OP_ADVANCE: begin
					if (!stop) begin
						prev_q     <= cur_q[IDX_W-1:0];
						has_prev_q <= 1'b1;
						cur_q      <= rd_link_q;
						steps_q    <= link_t'(steps_q + 1'b1);
					end
				end
				OP_WR_PREV: begin
					status_q     <= ST_INSERTED;
					item_value_q <= '0;
					slot_index_q <= slot_t'(count_idx);
					last_q       <= 1'b1;
				end
				OP_EMIT_FULL: begin
					status_q     <= ST_FULL;
					item_value_q <= '0;
					slot_index_q <= '0;
					last_q       <= 1'b1;
				end
				OP_EMIT_ELEM: begin
					status_q     <= ST_ELEMENT;
					item_value_q <= rd_val_q;
					slot_index_q <= slot_t'(cur_q[IDX_W-1:0]);
					last_q       <= last_elem;
					cur_q        <= rd_link_q;
					steps_q      <= link_t'(steps_q + 1'b1);
				end
				OP_EMIT_EMPTY: begin
					status_q     <= ST_EMPTY;
					item_value_q <= '0;
					slot_index_q <= '0;
					last_q       <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.item_value = item_value_q;
	assign rsp.slot_index = slot_index_q;
	assign rsp.last       = last_q;

	// fill count never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NULL_LINK)
		else $error("fill count above capacity");

	// fill count only ever grows by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == link_t'($past(count_q) + 1'b1)))
		else $error("fill count jumped");

	// head is null exactly when the list is empty
	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == (head_q == NULL_LINK))
		else $error("head and fill count disagree");

endmodule

// ===== sim/tb_sorted_static_linked_list.sv =====
// Testbench for sorted_static_linked_list: drives insert and read requests,
// predicts the ascending chain and checks every result field by field.
// Depends on ssll_pkg, ssll_if.sv and the RTL top.
module tb_sorted_static_linked_list import ssll_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam value_t VAL_MIN      = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam value_t VAL_MAX      = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam int     STALL_LIMIT  = 3000;
	localparam int     SETTLE_CYCLES = 2 * CAPACITY + 8;

	typedef struct packed {
		status_t status;
		value_t  item_value;
		slot_t   slot_index;
		logic    last;
	} list_result_t;

	logic clk;
	logic arst_n;

	ssll_req_if req_ch();
	ssll_rsp_if rsp_ch();

	sorted_static_linked_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow of the list: slot contents, links, head and fill level
	value_t list_vals  [CAPACITY];
	link_t  list_links [CAPACITY];
	link_t  list_head = NULL_LINK;
	int     list_fill = 0;

	list_result_t results_due [$];
	list_result_t want;
	value_t       corner_vals [4];

	int   mismatches   = 0;
	int   src_idle_pct = 0;
	int   snk_idle_pct = 0;
	int   hold_len     = 0;
	int   hold_left    = 0;
	logic hold_taken   = 1'b0;
	int   quiet_cycles = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic list_result_t make_result(status_t st, value_t val, slot_t slot,
		logic fin);
		list_result_t r;
		r.status     = st;
		r.item_value = val;
		r.slot_index = slot;
		r.last       = fin;
		return r;
	endfunction

	// apply one accepted request to the shadow list and queue its results
	function automatic void apply_list_op(logic op_mode, value_t val);
		link_t cur;
		link_t nxt;
		idx_t  prev;
		idx_t  slot;
		logic  has_prev;
		logic  stop;
		int    steps;
		int    n;
		if (op_mode == MODE_INSERT) begin
			if (list_fill >= CAPACITY) begin
				results_due.push_back(make_result(ST_FULL, '0, '0, 1'b1));
			end else begin
				slot     = idx_t'(list_fill);
				cur      = list_head;
				prev     = '0;
				has_prev = 1'b0;
				stop     = 1'b0;
				steps    = 0;
				// walk to the first stored value strictly greater than val
				while (!stop && cur < CAPACITY && steps < list_fill) begin
					if (list_vals[cur[IDX_W-1:0]] > val) begin
						stop = 1'b1;
					end else begin
						prev     = cur[IDX_W-1:0];
						has_prev = 1'b1;
						cur      = list_links[prev];
						steps++;
					end
				end
				if (cur >= CAPACITY)
					cur = NULL_LINK;
				list_vals[slot]  = val;
				list_links[slot] = cur;
				if (has_prev)
					list_links[prev] = link_t'(slot);
				else
					list_head = link_t'(slot);
				list_fill = list_fill + 1;
				results_due.push_back(make_result(ST_INSERTED, '0, slot_t'(slot), 1'b1));
			end
		end else begin
			n   = 0;
			cur = list_head;
			while (cur < CAPACITY && n < list_fill) begin
				nxt = list_links[cur[IDX_W-1:0]];
				results_due.push_back(make_result(ST_ELEMENT, list_vals[cur[IDX_W-1:0]],
					slot_t'(cur), (nxt >= CAPACITY) || (n + 1 >= list_fill)));
				n++;
				cur = nxt;
			end
			if (n == 0)
				results_due.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
		end
	endfunction

	// mix of small values (many ties), corner values and full-range values
	function automatic value_t pick_value();
		case ($urandom_range(3))
			0:       return value_t'($urandom_range(6)) - 3;
			1:       return corner_vals[$urandom_range(3)];
			default: return value_t'($urandom);
		endcase
	endfunction

	// send one request; called and returning at a falling edge
	task automatic send_request(logic op_mode, value_t val);
		if ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.mode      <= op_mode;
		req_ch.new_value <= val;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		apply_list_op(op_mode, val);
		@(negedge clk);
	endtask

	// sender goes quiet until every queued result has come back
	task automatic wait_results_done();
		req_ch.valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_empty_read();
		wait_results_done();
		send_request(MODE_READ, VAL_MAX);
	endtask

	// head, tail and middle inserts, corner values and ties, with reads of the chain
	task automatic test_insert_order();
		wait_results_done();
		send_request(MODE_INSERT, 0);
		send_request(MODE_READ, VAL_MIN);
		send_request(MODE_INSERT, VAL_MIN);
		send_request(MODE_INSERT, VAL_MAX);
		send_request(MODE_INSERT, 0);
		send_request(MODE_INSERT, -1);
		send_request(MODE_INSERT, VAL_MIN);
		send_request(MODE_INSERT, VAL_MAX);
		send_request(MODE_READ, 0);
	endtask

	task automatic test_random_traffic(int count, int src_pct, int snk_pct);
		wait_results_done();
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 45)
				send_request(MODE_READ, value_t'($urandom));
			else
				send_request(MODE_INSERT, pick_value());
		end
	endtask

	// fill whatever is left, then inserts must be refused
	task automatic test_full_store();
		wait_results_done();
		while (list_fill < CAPACITY)
			send_request(MODE_INSERT, pick_value());
		send_request(MODE_INSERT, VAL_MIN);
		send_request(MODE_INSERT, VAL_MAX);
		send_request(MODE_READ, -1);
		send_request(MODE_INSERT, 0);
	endtask

	// receiver holds off while reads keep coming, so the input stalls
	task automatic test_backpressure();
		wait_results_done();
		src_idle_pct = 0;
		@(posedge clk);
		hold_len = 200;
		@(negedge clk);
		repeat (6)
			send_request(MODE_READ, value_t'($urandom));
		wait_results_done();
	endtask

	// receiver ready, with an optional long hold-off counted here
	always @(negedge clk) begin
		if (hold_len > 0 && !hold_taken) begin
			hold_left  = hold_len;
			hold_taken = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// result check against the oldest queued expectation
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: result with none due: status %0d value %0d slot %0d last %0b",
					$time, rsp_ch.status, rsp_ch.item_value, rsp_ch.slot_index, rsp_ch.last);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				if (rsp_ch.status !== want.status) begin
					$display("%0t: status expected %0d, got %0d", $time, want.status,
						rsp_ch.status);
					mismatches++;
				end
				if (rsp_ch.item_value !== want.item_value) begin
					$display("%0t: item_value expected %0d, got %0d", $time, want.item_value,
						rsp_ch.item_value);
					mismatches++;
				end
				if (rsp_ch.slot_index !== want.slot_index) begin
					$display("%0t: slot_index expected %0d, got %0d", $time, want.slot_index,
						rsp_ch.slot_index);
					mismatches++;
				end
				if (rsp_ch.last !== want.last) begin
					$display("%0t: last expected %0b, got %0b", $time, want.last,
						rsp_ch.last);
					mismatches++;
				end
			end
		end
	end

	// watchdog: too long with no request and no result accepted
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("tb_sorted_static_linked_list failed");
				$finish;
			end
		end
	end

	initial begin
		corner_vals[0]   = VAL_MIN;
		corner_vals[1]   = VAL_MAX;
		corner_vals[2]   = 0;
		corner_vals[3]   = -1;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.mode      = MODE_INSERT;
		req_ch.new_value = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_read();
		test_insert_order();
		test_random_traffic(160, 37, 76);
		test_full_store();
		test_backpressure();
		test_random_traffic(160, 76, 37);
		test_random_traffic(160, 0, 0);

		wait_results_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_sorted_static_linked_list passed");
		else
			$display("tb_sorted_static_linked_list failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ssll_pkg.sv
hdl/ssll_if.sv
hdl/sorted_static_linked_list.sv
sim/tb_sorted_static_linked_list.sv
